/* rtl/spcp_pkg.sv */
// Package with the shared types and constants of the SPIR-V composite patcher.
`timescale 1ns / 1ps

package spcp_pkg;

	localparam int WORD_W      = 32;
	localparam int POS_W       = 23;
	localparam int HALF_W      = 16;
	localparam int MAX_RESULTS = 4;
	localparam int RES_CNT_W   = 3;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [HALF_W-1:0] half_t;

	localparam pos_t  FIRST_HEADER      = pos_t'(5);
	localparam pos_t  POS_MAX           = {POS_W{1'b1}};
	localparam half_t OP_SPEC_TRUE      = half_t'(48);
	localparam half_t OP_COMPOSITE      = half_t'(44);
	localparam half_t OP_SPEC_COMPOSITE = half_t'(51);
	localparam half_t MIN_LEN_SPEC_TRUE = half_t'(3);
	localparam half_t MIN_LEN_COMPOSITE = half_t'(4);

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_SPEC_TRUE,
		KIND_COMPOSITE
	} kind_t;

	// Control from the parser to the id table.
	typedef struct packed {
		logic push;
		logic clear;
	} tbl_ctl_t;

endpackage

/* rtl/spcp_id_cell.sv */
// One id table cell: holds one id, passes it on when the row shifts, compares it to the probe.
`timescale 1ns / 1ps

module spcp_id_cell
	import spcp_pkg::*;
(
	input  logic  clk,
	input  logic  shift_en,
	input  word_t id_in,
	output word_t id_out,
	input  word_t probe,
	input  logic  occupied,
	output logic  hit
);

	word_t id_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			id_q <= id_in;
		end
	end

	assign id_out = id_q;
	assign hit    = occupied && (id_q == probe);

endmodule

/* rtl/spcp_id_chain.sv */
// Row of id cells: new ids shift in at the head, every occupied cell is probed in parallel.
`timescale 1ns / 1ps

module spcp_id_chain
	import spcp_pkg::*;
#(
	parameter int ID_SLOTS = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  tbl_ctl_t ctl,
	input  word_t    push_id,
	input  word_t    probe,
	output logic     hit,
	output logic     full
);

	localparam int CNT_W = $clog2(ID_SLOTS + 1);

	logic [CNT_W-1:0]    count_q;
	word_t               ids [ID_SLOTS];
	logic [ID_SLOTS-1:0] hits;
	logic                shift_en;

	assign full     = (count_q == CNT_W'(ID_SLOTS));
	assign shift_en = ctl.push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.clear) begin
			count_q <= '0;
		end else if (shift_en) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	for (genvar i = 0; i < ID_SLOTS; i++) begin : g_cell
		word_t id_in;
		if (i == 0) begin : g_head
			assign id_in = push_id;
		end else begin : g_body
			assign id_in = ids[i-1];
		end
		spcp_id_cell u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.id_in    (id_in),
			.id_out   (ids[i]),
			.probe    (probe),
			.occupied (CNT_W'(i) < count_q),
			.hit      (hits[i])
		);
	end

	assign hit = |hits;

endmodule

/* rtl/spirv_composite_spec_patcher_core.sv */
// Top level of the SPIR-V composite patcher: word parser, result buffer and id table.
`timescale 1ns / 1ps

// Usage:
// Module words enter on code_valid/code_ready with module_start set on the first
// word of each module. Patched words leave on out_valid/out_ready, with run_end on
// the last word caused by one input transaction and table_full once an id was lost.
// The word count register is written on cfg_valid/cfg_ready (always ready); the
// user must write it only while idle, the block does not enforce this. An input word
// appears at the output in the cycle after its transaction. Throughput: one output
// word per cycle while the receiver is ready. An input word that causes result words
// occupies the result buffer until the last of them is delivered; the next word is
// taken in the cycle that last one is delivered. Words held for a composite cause no
// result; their release (up to four words at a module start) drains the four-entry
// result buffer one word per cycle while the receiver is ready. Id membership is
// settled combinationally by a parallel compare over the row of ID_SLOTS cells.
// Reset clears the parser, the id count and the result count; no clearing pass is
// needed. When the receiver stalls, the current word holds and no new input is taken.
module spirv_composite_spec_patcher_core
	import spcp_pkg::*;
#(
	parameter int ID_SLOTS = 64
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cfg_valid,
	output logic  cfg_ready,
	input  pos_t  cfg_data,
	input  logic  code_valid,
	output logic  code_ready,
	input  word_t code_word,
	input  logic  module_start,
	output logic  out_valid,
	input  logic  out_ready,
	output word_t out_word,
	output logic  run_end,
	output logic  table_full
);

	pos_t  code_words_q;
	pos_t  wpos_q, wpos_n;
	pos_t  nhp_q, nhp_n;
	kind_t kind_q, kind_n;
	logic [1:0] rel_q, rel_n;
	logic  stopped_q, stopped_n;
	logic  ovf_q, ovf_n;
	word_t held_q [3];
	word_t held_n [3];

	word_t res_q [MAX_RESULTS];
	word_t res_n [MAX_RESULTS];
	logic [RES_CNT_W-1:0] res_cnt_q, res_cnt_n;
	logic [1:0] res_idx_q;
	logic  res_full_q;

	tbl_ctl_t tbl_ctl;
	logic  tbl_hit, tbl_full;
	logic  accept, last_out;

	assign cfg_ready  = 1'b1;
	assign out_valid  = (res_cnt_q != '0);
	assign last_out   = ({1'b0, res_idx_q} == res_cnt_q - RES_CNT_W'(1));
	assign code_ready = !out_valid || (out_ready && last_out);
	assign accept     = code_valid && code_ready;
	assign out_word   = res_q[res_idx_q];
	assign run_end    = last_out;
	assign table_full = res_full_q;

	spcp_id_chain #(
		.ID_SLOTS (ID_SLOTS)
	) u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (tbl_ctl),
		.push_id (code_word),
		.probe   (code_word),
		.hit     (tbl_hit),
		.full    (tbl_full)
	);

	always_comb begin
		pos_t  pos;
		kind_t kind_e;
		pos_t  nhp_e;
		logic  stopped_e;
		logic  pass;
		half_t len, op;
		logic [RES_CNT_W-1:0] n;

		kind_e    = module_start ? KIND_NONE : kind_q;
		nhp_e     = module_start ? FIRST_HEADER : nhp_q;
		stopped_e = module_start ? 1'b0 : stopped_q;
		ovf_n     = module_start ? 1'b0 : ovf_q;
		pos       = module_start ? '0 : wpos_q;
		kind_n    = kind_e;
		nhp_n     = nhp_e;
		stopped_n = stopped_e;
		rel_n     = rel_q;
		held_n    = held_q;
		pass      = 1'b1;
		len       = code_word[WORD_W-1:HALF_W];
		op        = code_word[HALF_W-1:0];
		n         = '0;
		tbl_ctl.push  = 1'b0;
		tbl_ctl.clear = accept && module_start;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			res_n[i] = '0;
		end

		// A module start in the middle of a hold releases what was held, unpatched.
		if (module_start && kind_q == KIND_COMPOSITE) begin
			for (int i = 0; i < 3; i++) begin
				if (i < int'(rel_q)) begin
					res_n[i] = held_q[i];
				end
			end
			n = RES_CNT_W'(rel_q);
		end

		if (pos >= FIRST_HEADER && !stopped_e) begin
			unique case (kind_e)
				KIND_SPEC_TRUE: begin
					rel_n = rel_q + 2'd1;
					if (rel_q == 2'd2) begin
						tbl_ctl.push = accept;
						if (tbl_full) begin
							ovf_n = 1'b1;
						end
						kind_n = KIND_NONE;
					end
				end
				KIND_COMPOSITE: begin
					if (rel_q == 2'd1 || rel_q == 2'd2) begin
						held_n[rel_q] = code_word;
						rel_n = rel_q + 2'd1;
						pass  = 1'b0;
					end else begin
						res_n[n[1:0]] = tbl_hit
							? {held_q[0][WORD_W-1:HALF_W], OP_SPEC_COMPOSITE}
							: held_q[0];
						res_n[n[1:0] + 2'd1] = held_q[1];
						res_n[n[1:0] + 2'd2] = held_q[2];
						n = n + RES_CNT_W'(3);
						kind_n = KIND_NONE;
					end
				end
				default: begin
					if (pos == nhp_e) begin
						if (pos >= code_words_q || len == '0 ||
						    ({1'b0, pos} + (POS_W+1)'(len)) > {1'b0, code_words_q}) begin
							stopped_n = 1'b1;
						end else begin
							nhp_n = pos + POS_W'(len);
							if (op == OP_SPEC_TRUE && len >= MIN_LEN_SPEC_TRUE) begin
								held_n[0] = code_word;
								kind_n    = KIND_SPEC_TRUE;
								rel_n     = 2'd1;
							end else if (op == OP_COMPOSITE && len >= MIN_LEN_COMPOSITE) begin
								held_n[0] = code_word;
								kind_n    = KIND_COMPOSITE;
								rel_n     = 2'd1;
								pass      = 1'b0;
							end
						end
					end
				end
			endcase
		end

		if (pass) begin
			res_n[n[1:0]] = code_word;
			n = n + RES_CNT_W'(1);
		end

		wpos_n    = (pos == POS_MAX) ? pos : pos + POS_W'(1);
		res_cnt_n = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_words_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			code_words_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q    <= '0;
			nhp_q     <= FIRST_HEADER;
			kind_q    <= KIND_NONE;
			rel_q     <= '0;
			stopped_q <= 1'b0;
			ovf_q     <= 1'b0;
		end else if (accept) begin
			wpos_q    <= wpos_n;
			nhp_q     <= nhp_n;
			kind_q    <= kind_n;
			rel_q     <= rel_n;
			stopped_q <= stopped_n;
			ovf_q     <= ovf_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_q     <= held_n;
			res_q      <= res_n;
			res_full_q <= ovf_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= '0;
			res_idx_q <= '0;
		end else begin
			if (out_valid && out_ready) begin
				if (last_out) begin
					res_cnt_q <= '0;
				end else begin
					res_idx_q <= res_idx_q + 2'd1;
				end
			end
			if (accept) begin
				res_cnt_q <= res_cnt_n;
				res_idx_q <= '0;
			end
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, res_idx_q} < res_cnt_q))
		else $error("result index beyond result count");

	a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !run_end) |-> !code_ready)
		else $error("input taken while results of the previous word remain");

	a_hold_has_rel: assert property (@(posedge clk) disable iff (!arst_n)
		(kind_q != KIND_NONE) |-> (rel_q != 2'd0))
		else $error("instruction in progress without a word offset");

	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(stopped_q && !(accept && module_start)) |=> stopped_q)
		else $error("parse stop released without a module start");

endmodule
